// ----- design/repeat_unit_phase_finder_core_defines.svh -----
// Assertion helpers shared by the repeat unit phase finder RTL.
`ifndef REPEAT_UNIT_PHASE_FINDER_CORE_DEFINES_SVH
`define REPEAT_UNIT_PHASE_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RUPF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RUPF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rupf_pkg.sv -----
`default_nettype none

package rupf_pkg;

  // Fixed field widths
  localparam int PH_W      = 3;   // phase / counter memory address
  localparam int CNT_W     = 13;  // phase counter
  localparam int LEN_W     = 4;   // unit length register
  localparam int UCNT_W    = 3;   // unit count register
  localparam int BASE_W    = 8;   // one base
  localparam int HIST_W    = 64;  // eight most recent bases
  localparam int CFG_IDX_W = 3;
  localparam int NUM_PH    = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BASE = 3'd2;

  // Result scanner states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } scan_state_t;

  // Counter write-back from the accumulate stage
  typedef struct packed {
    logic             we;
    logic             bank;
    logic [PH_W-1:0]  addr;
    logic [CNT_W-1:0] data;
  } mem_wr_t;

  // End-of-read request toward the scanner
  typedef struct packed {
    logic             vld;
    logic             bank;
    logic [LEN_W-1:0] len;
  } scan_req_t;

  // Scanner access to the counter memories (read and clear)
  typedef struct packed {
    logic            en;
    logic            both;
    logic            bank;
    logic [PH_W-1:0] addr;
  } scan_port_t;

endpackage

`default_nettype wire

// ----- design/rupf_ram.sv -----
`default_nettype none

module rupf_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port, read-first
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/rupf_acc.sv -----
`default_nettype none
`include "repeat_unit_phase_finder_core_defines.svh"

module rupf_acc
  import rupf_pkg::*;
#(
  parameter int MAX_UNIT_LEN      = 8,
  parameter int NUM_UNIT_PATTERNS = 6,
  parameter int MAX_READ_LEN      = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire logic [BASE_W-1:0]   base_char,
  input  wire logic                last_base,
  input  wire logic [LEN_W-1:0]    unit_length,
  input  wire logic [UCNT_W-1:0]   unit_count,
  input  wire logic [HIST_W-1:0]   unit_pattern [NUM_UNIT_PATTERNS],
  input  wire logic [CNT_W-1:0]    rdata0,
  input  wire logic [CNT_W-1:0]    rdata1,
  output logic                     acc_bank,
  output logic      [PH_W-1:0]     rd_addr,
  output mem_wr_t                  wr,
  output scan_req_t                req
);

  localparam int SatInt = (MAX_READ_LEN < 8191) ? MAX_READ_LEN : 8191;
  localparam logic [CNT_W-1:0]  CountSat = CNT_W'(SatInt);
  localparam logic [LEN_W-1:0]  MaxLen   = LEN_W'(MAX_UNIT_LEN);
  localparam logic [UCNT_W-1:0] NumPat   = UCNT_W'(NUM_UNIT_PATTERNS);

  // Per-read state
  logic [HIST_W-1:0] recent_r, recent_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [LEN_W-1:0]  seen_r, seen_nxt;
  logic              bank_r, bank_nxt;

  // Read-modify-write stage
  logic              s1_vld_r;
  logic              s1_last_r;
  logic              s1_inc_r;
  logic [PH_W-1:0]   s1_addr_r;
  logic              s1_bank_r;
  logic [LEN_W-1:0]  s1_len_r;

  // Last write, for same-entry forwarding
  logic              fwd_vld_r;
  logic              fwd_bank_r;
  logic [PH_W-1:0]   fwd_addr_r;
  logic [CNT_W-1:0]  fwd_data_r;

  logic [LEN_W-1:0]  len_eff;
  logic [UCNT_W-1:0] en_cnt;
  logic [HIST_W-1:0] recent_calc;
  logic [LEN_W-1:0]  seen_calc;
  logic [PH_W-1:0]   phase_calc;
  logic [LEN_W-1:0]  phase_inc;
  logic [6:0]        shamt;
  logic [HIST_W-1:0] win;
  logic [NUM_UNIT_PATTERNS-1:0] pat_hit;
  logic              match;
  logic [CNT_W-1:0]  rdata_sel;
  logic              fwd_hit;
  logic [CNT_W-1:0]  cur;
  logic [CNT_W-1:0]  inc;

  // Effective unit length and enabled pattern count
  always_comb begin
    if (unit_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (unit_length > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = unit_length;
    end
    en_cnt = (unit_count > NumPat) ? NumPat : unit_count;
  end

  // Window shift, phase advance, base count
  always_comb begin
    recent_calc = {base_char, recent_r[HIST_W-1:BASE_W]};
    seen_calc   = (seen_r < LEN_W'(NUM_PH)) ? seen_r + LEN_W'(1) : seen_r;
    phase_inc   = {1'b0, phase_r} + LEN_W'(1);
    phase_calc  = (phase_inc >= len_eff) ? '0 : phase_inc[PH_W-1:0];
    shamt       = {LEN_W'(NUM_PH) - len_eff, 3'b000};
    win         = recent_calc >> shamt;
  end

  // Compare the newest window against every enabled pattern
  always_comb begin
    for (int k = 0; k < NUM_UNIT_PATTERNS; k++) begin
      pat_hit[k] = (k < int'(en_cnt));
      for (int j = 0; j < NUM_PH; j++) begin
        if (j < int'(len_eff) && unit_pattern[k][8*j +: 8] != win[8*j +: 8]) begin
          pat_hit[k] = 1'b0;
        end
      end
    end
    match = (seen_calc >= len_eff) && (|pat_hit);
  end

  // Next per-read state; the last base clears it and flips the bank
  always_comb begin
    recent_nxt = recent_r;
    phase_nxt  = phase_r;
    seen_nxt   = seen_r;
    bank_nxt   = bank_r;
    if (in_fire) begin
      if (last_base) begin
        recent_nxt = '0;
        phase_nxt  = '0;
        seen_nxt   = '0;
        bank_nxt   = ~bank_r;
      end else begin
        recent_nxt = recent_calc;
        phase_nxt  = phase_calc;
        seen_nxt   = seen_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r  <= '0;
      phase_r   <= '0;
      seen_r    <= '0;
      bank_r    <= 1'b0;
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      recent_r  <= recent_nxt;
      phase_r   <= phase_nxt;
      seen_r    <= seen_nxt;
      bank_r    <= bank_nxt;
      s1_vld_r  <= in_fire;
      fwd_vld_r <= wr.we;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= last_base;
      s1_inc_r  <= match;
      s1_addr_r <= phase_calc;
      s1_bank_r <= bank_r;
      s1_len_r  <= len_eff;
    end
    fwd_bank_r <= wr.bank;
    fwd_addr_r <= wr.addr;
    fwd_data_r <= wr.data;
  end

  // Counter read is issued in the accept cycle
  assign acc_bank = bank_r;
  assign rd_addr  = phase_calc;

  // Increment with forwarding of the previous cycle's write
  always_comb begin
    rdata_sel = s1_bank_r ? rdata1 : rdata0;
    fwd_hit   = fwd_vld_r && (fwd_bank_r == s1_bank_r) && (fwd_addr_r == s1_addr_r);
    cur       = fwd_hit ? fwd_data_r : rdata_sel;
    inc       = (cur < CountSat) ? cur + CNT_W'(1) : cur;
    wr.we     = s1_vld_r && s1_inc_r;
    wr.bank   = s1_bank_r;
    wr.addr   = s1_addr_r;
    wr.data   = inc;
    req.vld   = s1_vld_r && s1_last_r;
    req.bank  = s1_bank_r;
    req.len   = s1_len_r;
  end

  `RUPF_ASSERT_IMPL(a_wr_nonzero, clk, rst_n, wr.we, wr.data != '0, "counter write-back is zero")

endmodule

`default_nettype wire

// ----- design/rupf_scan.sv -----
`default_nettype none
`include "repeat_unit_phase_finder_core_defines.svh"

module rupf_scan
  import rupf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scan_req_t         req,
  input  wire logic [CNT_W-1:0]  rdata0,
  input  wire logic [CNT_W-1:0]  rdata1,
  output scan_port_t             port,
  output logic      [1:0]        bank_busy,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [PH_W-1:0]   out_best_phase,
  output logic      [CNT_W-1:0]  out_best_count
);

  scan_state_t      state_r, state_nxt;
  logic [PH_W-1:0]  cnt_r, cnt_nxt;
  logic             bank_r, bank_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // One pending end-of-read request
  logic             pend_vld_r, pend_vld_nxt;
  logic             pend_bank_r;
  logic [LEN_W-1:0] pend_len_r;

  // Read data alignment
  logic             rd_vld_r;
  logic [PH_W-1:0]  rd_addr_r;

  logic [CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [PH_W-1:0]  best_ph_r, best_ph_nxt;

  // Output register
  logic             out_vld_r, out_vld_nxt;
  logic [PH_W-1:0]  out_ph_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic             take;
  logic             load;
  logic [CNT_W-1:0] rdata;

  assign take  = (state_r == S_IDLE) && pend_vld_r;
  assign load  = (state_r == S_EMIT) && (!out_vld_r || out_ready);
  assign rdata = bank_r ? rdata1 : rdata0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:  if (cnt_r == PH_W'(NUM_PH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (pend_vld_r) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == PH_W'(NUM_PH - 1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_EMIT;
      S_EMIT:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sweep counter, scan context, best-so-far
  always_comb begin
    cnt_nxt      = cnt_r;
    bank_nxt     = bank_r;
    len_nxt      = len_r;
    best_cnt_nxt = best_cnt_r;
    best_ph_nxt  = best_ph_r;
    if (state_r == S_INIT || state_r == S_SCAN) begin
      cnt_nxt = cnt_r + PH_W'(1);
    end
    if (take) begin
      bank_nxt     = pend_bank_r;
      len_nxt      = pend_len_r;
      best_cnt_nxt = '0;
      best_ph_nxt  = '0;
    end else if (rd_vld_r && ({1'b0, rd_addr_r} < len_r) && (rdata > best_cnt_r)) begin
      best_cnt_nxt = rdata;
      best_ph_nxt  = rd_addr_r;
    end
  end

  // Pending request and output register valid
  always_comb begin
    if (req.vld) begin
      pend_vld_nxt = 1'b1;
    end else if (take) begin
      pend_vld_nxt = 1'b0;
    end else begin
      pend_vld_nxt = pend_vld_r;
    end
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Outputs: memory access and bank occupancy
  always_comb begin
    port.en   = (state_r == S_INIT) || (state_r == S_SCAN);
    port.both = (state_r == S_INIT);
    port.bank = bank_r;
    port.addr = cnt_r;
    for (int b = 0; b < 2; b++) begin
      bank_busy[b] = (state_r == S_INIT)
                  || ((state_r != S_IDLE) && (bank_r == 1'(b)))
                  || (pend_vld_r && (pend_bank_r == 1'(b)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      rd_vld_r   <= (state_r == S_SCAN);
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r     <= bank_nxt;
    len_r      <= len_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_ph_r  <= best_ph_nxt;
    rd_addr_r  <= cnt_r;
    if (req.vld) begin
      pend_bank_r <= req.bank;
      pend_len_r  <= req.len;
    end
    if (load) begin
      out_ph_r  <= best_ph_r;
      out_cnt_r <= best_cnt_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_best_phase = out_ph_r;
  assign out_best_count = out_cnt_r;

  `RUPF_ASSERT_IMPL(a_pend_room, clk, rst_n, req.vld && pend_vld_r, state_r == S_IDLE, "pending request overrun")
  `RUPF_ASSERT_IMPL(a_rd_align, clk, rst_n, rd_vld_r, state_r == S_SCAN || state_r == S_DRAIN, "scan data out of step")

endmodule

`default_nettype wire

// ----- design/repeat_unit_phase_finder_core.sv -----
// Tandem repeat phase finder.
// Input channel (in_valid/in_ready): one read base per transaction, in_last_base
// marks the final base. Result channel (out_valid/out_ready): one transaction per
// read carrying the phase with the most matching unit windows (lowest on ties)
// and that count. Config channel (cfg_valid/cfg_ready, cfg_index/cfg_data):
// always ready; the user must write it only with no read in flight (not enforced).
// Throughput: one base per cycle while in_ready is high; each base costs one
// read-modify-write of a phase counter memory, with the previous write forwarded
// when it hits the same entry. Two counter banks alternate between reads. When a
// read ends, its bank is scanned and cleared while the next read streams into
// the other bank; a read that ends before the previous scan is done holds in_ready
// low until that bank frees, so reads of 12 or more bases sustain full rate.
// Result path: the end-of-read request is registered as pending, the bank is
// scanned and drained, and the result is loaded into the output register if free.
// Reset: a clearing pass over both banks runs, in_ready low meanwhile.
// Output stall: the result waits in the output register; the scan of the next read
// then waits too, and the input keeps running until it needs that bank.
`default_nettype none
`include "repeat_unit_phase_finder_core_defines.svh"

module repeat_unit_phase_finder_core
  import rupf_pkg::*;
#(
  parameter int MAX_UNIT_LEN      = 8,
  parameter int NUM_UNIT_PATTERNS = 6,
  parameter int MAX_READ_LEN      = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BASE_W-1:0]     in_base_char,
  input  wire logic                  in_last_base,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PH_W-1:0]       out_best_phase,
  output logic      [CNT_W-1:0]      out_best_count,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [HIST_W-1:0]     cfg_data
);

  logic [LEN_W-1:0]  unit_length_r;
  logic [UCNT_W-1:0] unit_count_r;
  logic [HIST_W-1:0] unit_pattern_r [NUM_UNIT_PATTERNS];

  logic              in_fire;
  logic              cfg_fire;
  logic              acc_bank;
  logic [PH_W-1:0]   acc_rd_addr;
  mem_wr_t           acc_wr;
  scan_req_t         scan_req;
  scan_port_t        scan_port;
  logic [1:0]        bank_busy;

  logic              ram_we    [2];
  logic [PH_W-1:0]   ram_waddr [2];
  logic [CNT_W-1:0]  ram_wdata [2];
  logic [PH_W-1:0]   ram_raddr [2];
  logic [CNT_W-1:0]  ram_rdata [2];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !bank_busy[acc_bank];
  assign in_fire   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_length_r <= LEN_W'(3);
      unit_count_r  <= UCNT_W'(1);
      for (int k = 0; k < NUM_UNIT_PATTERNS; k++) begin
        unit_pattern_r[k] <= '0;
      end
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_UNIT_LENGTH: unit_length_r <= cfg_data[LEN_W-1:0];
        CFG_UNIT_COUNT:  unit_count_r  <= cfg_data[UCNT_W-1:0];
        default: begin
          for (int k = 0; k < NUM_UNIT_PATTERNS; k++) begin
            if (cfg_index == CFG_PATTERN_BASE + CFG_IDX_W'(k)) begin
              unit_pattern_r[k] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  rupf_acc #(
    .MAX_UNIT_LEN      (MAX_UNIT_LEN),
    .NUM_UNIT_PATTERNS (NUM_UNIT_PATTERNS),
    .MAX_READ_LEN      (MAX_READ_LEN)
  ) u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .base_char    (in_base_char),
    .last_base    (in_last_base),
    .unit_length  (unit_length_r),
    .unit_count   (unit_count_r),
    .unit_pattern (unit_pattern_r),
    .rdata0       (ram_rdata[0]),
    .rdata1       (ram_rdata[1]),
    .acc_bank     (acc_bank),
    .rd_addr      (acc_rd_addr),
    .wr           (acc_wr),
    .req          (scan_req)
  );

  rupf_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (scan_req),
    .rdata0         (ram_rdata[0]),
    .rdata1         (ram_rdata[1]),
    .port           (scan_port),
    .bank_busy      (bank_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_phase (out_best_phase),
    .out_best_count (out_best_count)
  );

  // Counter banks: the scanner owns a bank while it sweeps it
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic scan_own;
    assign scan_own     = scan_port.en && (scan_port.both || (scan_port.bank == 1'(b)));
    assign ram_we[b]    = scan_own || (acc_wr.we && (acc_wr.bank == 1'(b)));
    assign ram_waddr[b] = scan_own ? scan_port.addr : acc_wr.addr;
    assign ram_wdata[b] = scan_own ? '0 : acc_wr.data;
    assign ram_raddr[b] = scan_own ? scan_port.addr : acc_rd_addr;

    rupf_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_PH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (ram_waddr[b]),
      .wdata (ram_wdata[b]),
      .raddr (ram_raddr[b]),
      .rdata (ram_rdata[b])
    );
  end

  `RUPF_ASSERT_IMPL(a_no_bank_clash, clk, rst_n, scan_port.en && acc_wr.we, !scan_port.both && (scan_port.bank != acc_wr.bank), "scanner and accumulator on one bank")

endmodule

`default_nettype wire
